// ===== rtl/core/ttf_pkg.sv =====
// ----------------------------------------------------------------------------
// ttf_pkg
// shared types and constants for the triangle tangent frame block
// ----------------------------------------------------------------------------
package ttf_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIFF,
        ST_FIT,
        ST_MUL,
        ST_SUM,
        ST_VSEL,
        ST_NRM_MAX,
        ST_NRM_SHIFT,
        ST_NRM_SQ,
        ST_NRM_SQSUM,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_NRM_STORE,
        ST_EMIT
    } ttf_state_t;

    typedef struct packed {
        logic        load_vtx;
        logic        do_diff;
        logic        do_fit;
        logic        do_mul;
        logic        do_sum;
        logic [1:0]  vsel;
        logic        do_max;
        logic        do_shift;
        logic        do_sq;
        logic        do_sqsum;
        logic        sqrt_start;
        logic        sqrt_step;
        logic        div_start;
        logic        div_step;
        logic        do_store;
        logic [1:0]  emit_idx;
    } ttf_cmd_t;

    typedef struct packed {
        logic        sqrt_done;
        logic        div_done;
        logic        det_zero;
    } ttf_sts_t;

    // vector being normalized
    localparam logic [1:0] VEC_FACE = 2'd0;
    localparam logic [1:0] VEC_TAN  = 2'd1;
    localparam logic [1:0] VEC_BIT  = 2'd2;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 48;

    // block fit bound for edges and deltas
    localparam logic [32:0] FIT_LIMIT = 33'd1 << 30;

endpackage

// ===== rtl/core/ttf_datapath.sv =====
// ----------------------------------------------------------------------------
// ttf_datapath
// vertex holding, edge math, and a shared sqrt/divide normalizer
// ----------------------------------------------------------------------------
module ttf_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ttf_pkg::ttf_cmd_t     cmd,
    output ttf_pkg::ttf_sts_t     sts,
    input  logic                  renorm,
    input  logic [1:0]            slot,
    input  logic signed [31:0]    pos_x,
    input  logic signed [31:0]    pos_y,
    input  logic signed [31:0]    pos_z,
    input  logic signed [31:0]    tex_u,
    input  logic signed [31:0]    tex_v,
    input  logic signed [15:0]    norm_x,
    input  logic signed [15:0]    norm_y,
    input  logic signed [15:0]    norm_z,
    output logic signed [15:0]    out_norm_x,
    output logic signed [15:0]    out_norm_y,
    output logic signed [15:0]    out_norm_z,
    output logic signed [15:0]    tangent_x,
    output logic signed [15:0]    tangent_y,
    output logic signed [15:0]    tangent_z,
    output logic signed [15:0]    bitangent_x,
    output logic signed [15:0]    bitangent_y,
    output logic signed [15:0]    bitangent_z,
    output logic                  frame_valid
);
    import ttf_pkg::*;

    logic signed [31:0] hp_reg [3][3];
    logic signed [31:0] ht_reg [3][2];
    logic signed [15:0] hn_reg [3][3];

    logic signed [32:0] e_reg [6];
    logic signed [32:0] d_reg [4];
    logic signed [63:0] pa_reg [10];
    logic signed [63:0] pb_reg [10];
    logic signed [63:0] det_reg;
    logic signed [63:0] cr_reg [3];
    logic signed [63:0] tv_reg [3];
    logic signed [63:0] bv_reg [3];

    logic [63:0] vm_reg [3];
    logic        vneg_reg [3];
    logic [63:0] mx_reg;
    logic [31:0] m_reg [3];
    logic [62:0] sq_reg [3];
    logic [63:0] s_reg;
    logic [63:0] rem_reg;
    logic [63:0] root_reg;
    logic [5:0]  sq_cnt_reg;
    logic [1:0]  dsel_reg;
    logic [47:0] dnum_reg;
    logic [32:0] dden_reg;
    logic [16:0] dq_reg;
    logic [48:0] drem_reg;
    logic [5:0]  dcnt_reg;

    logic signed [15:0] face_reg [3];
    logic signed [15:0] tan_reg [3];
    logic signed [15:0] bit_reg [3];

    // vertex capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_vtx)
        begin
            hp_reg[slot][0] <= pos_x;
            hp_reg[slot][1] <= pos_y;
            hp_reg[slot][2] <= pos_z;
            ht_reg[slot][0] <= tex_u;
            ht_reg[slot][1] <= tex_v;
            hn_reg[slot][0] <= norm_x;
            hn_reg[slot][1] <= norm_y;
            hn_reg[slot][2] <= norm_z;
        end
    end

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        mag33 = v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic signed [32:0] shr33(input logic signed [32:0] v,
                                                 input logic [1:0] s);
        logic [32:0] m;
        m = mag33(v) >> s;
        shr33 = v[32] ? -$signed(m) : $signed(m);
    endfunction

    logic [32:0] emx, dmx;
    logic [1:0]  es, ds;
    always_comb
    begin
        emx = '0;
        dmx = '0;
        for (int i = 0; i < 6; i++)
            if (mag33(e_reg[i]) > emx) emx = mag33(e_reg[i]);
        for (int i = 0; i < 4; i++)
            if (mag33(d_reg[i]) > dmx) dmx = mag33(d_reg[i]);
        es = (emx > FIT_LIMIT) ? (((emx >> 1) > FIT_LIMIT) ? 2'd2 : 2'd1) : 2'd0;
        ds = (dmx > FIT_LIMIT) ? (((dmx >> 1) > FIT_LIMIT) ? 2'd2 : 2'd1) : 2'd0;
    end

    // difference, block fit, product and sum stages
    always_ff @(posedge clk)
    begin
        if (cmd.do_diff)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e_reg[i]   <= 33'(hp_reg[1][i]) - 33'(hp_reg[0][i]);
                e_reg[3+i] <= 33'(hp_reg[2][i]) - 33'(hp_reg[0][i]);
            end
            d_reg[0] <= 33'(ht_reg[1][0]) - 33'(ht_reg[0][0]);
            d_reg[1] <= 33'(ht_reg[1][1]) - 33'(ht_reg[0][1]);
            d_reg[2] <= 33'(ht_reg[2][0]) - 33'(ht_reg[0][0]);
            d_reg[3] <= 33'(ht_reg[2][1]) - 33'(ht_reg[0][1]);
        end
        if (cmd.do_fit)
        begin
            for (int i = 0; i < 6; i++) e_reg[i] <= shr33(e_reg[i], es);
            for (int i = 0; i < 4; i++) d_reg[i] <= shr33(d_reg[i], ds);
        end
        if (cmd.do_mul)
        begin
            pa_reg[0] <= 64'(d_reg[0] * d_reg[3]);
            pb_reg[0] <= 64'(d_reg[2] * d_reg[1]);
            pa_reg[1] <= 64'(e_reg[1] * e_reg[5]);
            pb_reg[1] <= 64'(e_reg[2] * e_reg[4]);
            pa_reg[2] <= 64'(e_reg[2] * e_reg[3]);
            pb_reg[2] <= 64'(e_reg[0] * e_reg[5]);
            pa_reg[3] <= 64'(e_reg[0] * e_reg[4]);
            pb_reg[3] <= 64'(e_reg[1] * e_reg[3]);
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[4+i] <= 64'(d_reg[3] * e_reg[i]);
                pb_reg[4+i] <= 64'(d_reg[1] * e_reg[3+i]);
                pa_reg[7+i] <= 64'(d_reg[0] * e_reg[3+i]);
                pb_reg[7+i] <= 64'(d_reg[2] * e_reg[i]);
            end
        end
        if (cmd.do_sum)
        begin
            det_reg <= pa_reg[0] - pb_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                cr_reg[i] <= pa_reg[1+i] - pb_reg[1+i];
                tv_reg[i] <= pa_reg[4+i] - pb_reg[4+i];
                bv_reg[i] <= pa_reg[7+i] - pb_reg[7+i];
            end
        end
    end

    // normalizer: select vector, scale, squares, root, three divides
    // scale puts the largest magnitude's top bit at bit 30
    logic [5:0] msb;
    always_comb
    begin
        msb = '0;
        for (int k = 0; k < 64; k++)
            if (mx_reg[k]) msb = 6'(k);
    end

    logic [63:0] sq_bit;
    logic [63:0] trial;
    always_comb
    begin
        sq_bit = 64'(1) << (6'(62) - {sq_cnt_reg[4:0], 1'b0});
        trial  = root_reg + sq_bit;
    end

    logic [48:0] drem_sh;
    always_comb
        drem_sh = {drem_reg[47:0], dnum_reg[47]};

    always_ff @(posedge clk)
    begin
        if (cmd.do_max)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic signed [63:0] v;
                v = (cmd.vsel == VEC_FACE) ? cr_reg[i] :
                    (cmd.vsel == VEC_TAN)  ? (det_reg[63] ? -tv_reg[i] : tv_reg[i]) :
                                             (det_reg[63] ? -bv_reg[i] : bv_reg[i]);
                vneg_reg[i] <= v[63];
                vm_reg[i]   <= v[63] ? 64'(-v) : 64'(v);
            end
        end
        if (cmd.do_shift)
        begin
            mx_reg <= (vm_reg[0] > vm_reg[1]) ?
                      ((vm_reg[0] > vm_reg[2]) ? vm_reg[0] : vm_reg[2]) :
                      ((vm_reg[1] > vm_reg[2]) ? vm_reg[1] : vm_reg[2]);
        end
        if (cmd.do_sq)
        begin
            for (int i = 0; i < 3; i++)
                m_reg[i] <= (msb < 6'd30) ? 32'(vm_reg[i] << (6'd30 - msb))
                                          : 32'(vm_reg[i] >> (msb - 6'd30));
        end
        if (cmd.do_sqsum)
        begin
            for (int i = 0; i < 3; i++) sq_reg[i] <= 63'(m_reg[i]) * 63'(m_reg[i]);
        end
        if (cmd.sqrt_start)
        begin
            s_reg      <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            rem_reg    <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            root_reg   <= '0;
            sq_cnt_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + sq_bit;
            end
            else
                root_reg <= root_reg >> 1;
            sq_cnt_reg <= sq_cnt_reg + 6'd1;
        end
        if (cmd.div_start)
        begin
            dnum_reg <= {1'b0, m_reg[dsel_reg], 15'b0} + 48'(root_reg);
            dden_reg <= {root_reg[31:0], 1'b0};
            drem_reg <= '0;
            dq_reg   <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dnum_reg <= dnum_reg << 1;
            if (drem_sh >= 49'(dden_reg))
            begin
                drem_reg <= drem_sh - 49'(dden_reg);
                dq_reg   <= {dq_reg[15:0], 1'b1};
            end
            else
            begin
                drem_reg <= drem_sh;
                dq_reg   <= {dq_reg[15:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 6'd1;
        end
        if (cmd.do_store)
        begin
            logic signed [15:0] r;
            r = (s_reg == 64'd0) ? 16'sd0 :
                (vneg_reg[dsel_reg] ? -$signed(dq_reg[15:0]) : $signed(dq_reg[15:0]));
            case (cmd.vsel)
                VEC_FACE: face_reg[dsel_reg] <= r;
                VEC_TAN:  tan_reg[dsel_reg]  <= r;
                default:  bit_reg[dsel_reg]  <= r;
            endcase
        end
    end

    // divide lane counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dsel_reg <= '0;
        else if (cmd.do_max)
            dsel_reg <= '0;
        else if (cmd.do_store)
            dsel_reg <= (dsel_reg == 2'd2) ? 2'd0 : dsel_reg + 2'd1;
    end

    // dividend is 47 significant bits; 48 steps walks them all
    assign sts.sqrt_done = sq_cnt_reg == 6'(SQRT_STEPS - 1);
    assign sts.div_done  = dcnt_reg == 6'(DIV_STEPS - 1);
    assign sts.det_zero  = det_reg == 64'd0;

    always_comb
    begin
        out_norm_x = renorm ? face_reg[0] : hn_reg[cmd.emit_idx][0];
        out_norm_y = renorm ? face_reg[1] : hn_reg[cmd.emit_idx][1];
        out_norm_z = renorm ? face_reg[2] : hn_reg[cmd.emit_idx][2];
    end
    // tangent and bitangent are skipped when the determinant is zero
    assign tangent_x   = frame_valid ? tan_reg[0] : 16'sd0;
    assign tangent_y   = frame_valid ? tan_reg[1] : 16'sd0;
    assign tangent_z   = frame_valid ? tan_reg[2] : 16'sd0;
    assign bitangent_x = frame_valid ? bit_reg[0] : 16'sd0;
    assign bitangent_y = frame_valid ? bit_reg[1] : 16'sd0;
    assign bitangent_z = frame_valid ? bit_reg[2] : 16'sd0;
    assign frame_valid = det_reg != 64'd0;

endmodule

// ===== rtl/core/ttf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttf_ctrl
// sequencer for vertex capture, frame math and result emission
// ----------------------------------------------------------------------------
module ttf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               last,
    output logic [1:0]         slot,
    output ttf_pkg::ttf_cmd_t  cmd,
    input  ttf_pkg::ttf_sts_t  sts
);
    import ttf_pkg::*;

    ttf_state_t state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] vec_reg, vec_next;
    logic [1:0] lane_reg, lane_next;
    logic [1:0] emit_reg, emit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            vec_reg   <= VEC_FACE;
            lane_reg  <= '0;
            emit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vec_reg   <= vec_next;
            lane_reg  <= lane_next;
            emit_reg  <= emit_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        vec_next   = vec_reg;
        lane_next  = lane_reg;
        emit_next  = emit_reg;
        cmd        = '0;
        cmd.vsel   = vec_reg;
        cmd.emit_idx = emit_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        last       = emit_reg == 2'd2;
        slot       = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_vtx = 1'b1;
                    if (cnt_reg == 2'd2)
                    begin
                        cnt_next   = '0;
                        state_next = ST_DIFF;
                    end
                    else
                        cnt_next = cnt_reg + 2'd1;
                end
            end
            ST_DIFF:   begin cmd.do_diff = 1'b1; state_next = ST_FIT; end
            ST_FIT:    begin cmd.do_fit  = 1'b1; state_next = ST_MUL; end
            ST_MUL:    begin cmd.do_mul  = 1'b1; state_next = ST_SUM; end
            ST_SUM:
            begin
                cmd.do_sum = 1'b1;
                vec_next   = VEC_FACE;
                state_next = ST_VSEL;
            end
            ST_VSEL:
            begin
                cmd.do_max = 1'b1;
                state_next = ST_NRM_MAX;
            end
            ST_NRM_MAX: begin cmd.do_shift = 1'b1; state_next = ST_NRM_SHIFT; end
            ST_NRM_SHIFT: begin cmd.do_sq = 1'b1; state_next = ST_NRM_SQ; end
            ST_NRM_SQ:  begin cmd.do_sqsum = 1'b1; state_next = ST_NRM_SQSUM; end
            ST_NRM_SQSUM: begin cmd.sqrt_start = 1'b1; state_next = ST_SQRT; end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_done)
                begin
                    lane_next  = '0;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = ST_NRM_STORE;
            end
            ST_NRM_STORE:
            begin
                cmd.do_store = 1'b1;
                if (lane_reg == 2'd2)
                begin
                    if (vec_reg == VEC_BIT || (vec_reg == VEC_FACE && sts.det_zero))
                    begin
                        emit_next  = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        vec_next   = vec_reg + 2'd1;
                        state_next = ST_VSEL;
                    end
                end
                else
                begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (emit_reg == 2'd2)
                        state_next = ST_IDLE;
                    else
                        emit_next = emit_reg + 2'd1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/triangle_tangent_frame.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_frame
// per-triangle tangent and bitangent frame generator
// ----------------------------------------------------------------------------
// Vertices arrive one request at a time on the in channel (in_valid /
// in_stall). The first two are buffered. The third starts the frame
// computation: edge and delta math (difference, fit, multiply, sum), then
// up to three vector normalizations (face, tangent, bitangent) on one
// shared bit-serial square root (32 steps) and one shared restoring divider
// (48 steps per component). When the texcoord determinant is zero only
// the face normal is computed. No new vertex is taken until the frame is
// computed and emitted.
// The three results then leave on the out channel (out_valid / out_stall),
// one per accepted cycle; last_of_triangle marks the third. While the out
// side stalls, the result is held and no new vertex is taken.
// renormalize is to be written through renormalize_we / renormalize_wd only
// while idle; the block itself does not enforce this. Reset clears the vertex counter, the sequencer and the register.
// ----------------------------------------------------------------------------
module triangle_tangent_frame (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               renormalize_we,
    input  logic               renormalize_wd,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] tex_u,
    input  logic signed [31:0] tex_v,
    input  logic signed [15:0] norm_x,
    input  logic signed [15:0] norm_y,
    input  logic signed [15:0] norm_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] out_norm_x,
    output logic signed [15:0] out_norm_y,
    output logic signed [15:0] out_norm_z,
    output logic signed [15:0] tangent_x,
    output logic signed [15:0] tangent_y,
    output logic signed [15:0] tangent_z,
    output logic signed [15:0] bitangent_x,
    output logic signed [15:0] bitangent_y,
    output logic signed [15:0] bitangent_z,
    output logic               frame_valid,
    output logic               last_of_triangle
);
    import ttf_pkg::*;

    logic      renorm_reg;
    ttf_cmd_t  cmd;
    ttf_sts_t  sts;
    logic [1:0] slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            renorm_reg <= 1'b0;
        else if (renormalize_we)
            renorm_reg <= renormalize_wd;
    end

    ttf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .last      (last_of_triangle),
        .slot      (slot),
        .cmd       (cmd),
        .sts       (sts)
    );

    ttf_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .renorm      (renorm_reg),
        .slot        (slot),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .tex_u       (tex_u),
        .tex_v       (tex_v),
        .norm_x      (norm_x),
        .norm_y      (norm_y),
        .norm_z      (norm_z),
        .out_norm_x  (out_norm_x),
        .out_norm_y  (out_norm_y),
        .out_norm_z  (out_norm_z),
        .tangent_x   (tangent_x),
        .tangent_y   (tangent_y),
        .tangent_z   (tangent_z),
        .bitangent_x (bitangent_x),
        .bitangent_y (bitangent_y),
        .bitangent_z (bitangent_z),
        .frame_valid (frame_valid)
    );

endmodule

// ===== tb/triangle_tangent_frame_checker.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_frame_checker
// watches the vertex and frame channels and checks every frame
// ----------------------------------------------------------------------------
// Each accepted vertex request is fed to a local model of the block. On the
// third vertex of a triangle the model queues three expected frames. Each
// accepted frame is compared field by field with the oldest queued frame.
// ----------------------------------------------------------------------------
module triangle_tangent_frame_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               renormalize_we,
    input  logic               renormalize_wd,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] tex_u,
    input  logic signed [31:0] tex_v,
    input  logic signed [15:0] norm_x,
    input  logic signed [15:0] norm_y,
    input  logic signed [15:0] norm_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] out_norm_x,
    input  logic signed [15:0] out_norm_y,
    input  logic signed [15:0] out_norm_z,
    input  logic signed [15:0] tangent_x,
    input  logic signed [15:0] tangent_y,
    input  logic signed [15:0] tangent_z,
    input  logic signed [15:0] bitangent_x,
    input  logic signed [15:0] bitangent_y,
    input  logic signed [15:0] bitangent_z,
    input  logic               frame_valid,
    input  logic               last_of_triangle,
    output int                 fail_count,
    output int                 frames_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] nrm [3];
        logic signed [15:0] tan [3];
        logic signed [15:0] bit_v [3];
        logic               valid;
        logic               last;
    } frame_t;

    frame_t expected_frames [$];

    logic               renorm_mode;
    int                 vtx_count;
    longint             held_pos [2][3];
    longint             held_tex [2][2];
    longint             held_nrm [2][3];

    assign frames_pending = expected_frames.size();

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // common right shift until every magnitude is at most 2^30
    function automatic void fit_block(ref longint v [6], input int n);
        longint mx;
        int     s;
        mx = 0;
        s  = 0;
        for (int i = 0; i < n; i++)
            if (abs64(v[i]) > mx)
                mx = abs64(v[i]);
        while ((mx >>> s) > (64'sd1 <<< 30))
            s++;
        for (int i = 0; i < n; i++)
            v[i] = v[i] < 0 ? -(abs64(v[i]) >>> s) : (v[i] >>> s);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void unit_vector(input longint v [3], output logic signed [15:0] u [3]);
        longint unsigned m [3];
        longint unsigned mx, sq, len;
        int              sh;
        mx = 0;
        sq = 0;
        sh = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = abs64(v[i]);
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
        begin
            for (int i = 0; i < 3; i++)
                u[i] = '0;
            return;
        end
        if (mx < (64'd1 << 30))
        begin
            while ((mx << sh) < (64'd1 << 30))
                sh++;
            for (int i = 0; i < 3; i++)
                m[i] <<= sh;
        end
        else
        begin
            while ((mx >> sh) >= (64'd1 << 31))
                sh++;
            for (int i = 0; i < 3; i++)
                m[i] >>= sh;
        end
        for (int i = 0; i < 3; i++)
            sq += m[i] * m[i];
        len = floor_sqrt(sq);
        for (int i = 0; i < 3; i++)
        begin
            longint q;
            q = longint'(((m[i] << 15) + len) / (2 * len));
            u[i] = 16'(v[i] < 0 ? -q : q);
        end
    endfunction

    task automatic take_vertex(input longint p [3], input longint t [2], input longint n [3]);
        longint e [6];
        longint d [6];
        longint det, tv [3], bv [3], cr [3];
        logic signed [15:0] face [3], tan [3], bt [3];
        frame_t f;
        if (vtx_count < 2)
        begin
            held_pos[vtx_count] = p;
            held_tex[vtx_count] = t;
            held_nrm[vtx_count] = n;
            vtx_count++;
            return;
        end
        vtx_count = 0;
        for (int i = 0; i < 3; i++)
        begin
            e[i]     = held_pos[1][i] - held_pos[0][i];
            e[3 + i] = p[i] - held_pos[0][i];
        end
        d[0] = held_tex[1][0] - held_tex[0][0];
        d[1] = held_tex[1][1] - held_tex[0][1];
        d[2] = t[0] - held_tex[0][0];
        d[3] = t[1] - held_tex[0][1];
        d[4] = 0;
        d[5] = 0;
        fit_block(e, 6);
        fit_block(d, 4);
        det = d[0] * d[3] - d[2] * d[1];
        cr[0] = e[1] * e[5] - e[2] * e[4];
        cr[1] = e[2] * e[3] - e[0] * e[5];
        cr[2] = e[0] * e[4] - e[1] * e[3];
        unit_vector(cr, face);
        for (int i = 0; i < 3; i++)
        begin
            tan[i] = '0;
            bt[i]  = '0;
        end
        if (det != 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tv[i] = d[3] * e[i] - d[1] * e[3 + i];
                bv[i] = d[0] * e[3 + i] - d[2] * e[i];
                if (det < 0)
                begin
                    tv[i] = -tv[i];
                    bv[i] = -bv[i];
                end
            end
            unit_vector(tv, tan);
            unit_vector(bv, bt);
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                f.nrm[i]   = renorm_mode ? face[i] : 16'(k < 2 ? held_nrm[k][i] : n[i]);
                f.tan[i]   = tan[i];
                f.bit_v[i] = bt[i];
            end
            f.valid = det != 0;
            f.last  = k == 2;
            expected_frames.insert(expected_frames.size(), f);
        end
    endtask

    task automatic compare(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count  = 0;
        renorm_mode = 1'b0;
        vtx_count   = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (renormalize_we)
                renorm_mode <= renormalize_wd;
            if (out_valid && !out_stall)
            begin
                if (expected_frames.size() == 0)
                begin
                    $error("frame with no request pending");
                    fail_count++;
                end
                else
                begin
                    frame_t f;
                    f = expected_frames.pop_front();
                    compare("out_norm_x", f.nrm[0], out_norm_x);
                    compare("out_norm_y", f.nrm[1], out_norm_y);
                    compare("out_norm_z", f.nrm[2], out_norm_z);
                    compare("tangent_x", f.tan[0], tangent_x);
                    compare("tangent_y", f.tan[1], tangent_y);
                    compare("tangent_z", f.tan[2], tangent_z);
                    compare("bitangent_x", f.bit_v[0], bitangent_x);
                    compare("bitangent_y", f.bit_v[1], bitangent_y);
                    compare("bitangent_z", f.bit_v[2], bitangent_z);
                    compare("frame_valid", f.valid, frame_valid);
                    compare("last_of_triangle", f.last, last_of_triangle);
                end
            end
            if (in_valid && !in_stall)
                take_vertex('{pos_x, pos_y, pos_z}, '{tex_u, tex_v},
                            '{norm_x, norm_y, norm_z});
        end
    end

endmodule

// ===== tb/triangle_tangent_frame_tb.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_frame_tb
// stimulus and verdict for the triangle tangent frame block
// ----------------------------------------------------------------------------
// Sends directed triangles (extreme coordinates, zero determinant, degenerate
// and repeated vertices), then random triangles under both normal modes with
// random idling on both channels. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module triangle_tangent_frame_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               renormalize_we = 1'b0;
    logic               renormalize_wd = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
    logic signed [15:0] norm_x = '0, norm_y = '0, norm_z = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] out_norm_x, out_norm_y, out_norm_z;
    logic signed [15:0] tangent_x, tangent_y, tangent_z;
    logic signed [15:0] bitangent_x, bitangent_y, bitangent_z;
    logic               frame_valid, last_of_triangle;
    int                 fail_count, frames_pending;
    logic               no_idle = 1'b0;

    localparam int IDLE_PCT = 37;

    always #5 clk = ~clk;

    triangle_tangent_frame uut (.*);
    triangle_tangent_frame_checker checker_i (.*);

    always @(posedge clk)
        out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            2: return 32'($signed($urandom_range(64)) - 32);
            default: return 32'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    // in_valid stays high after an accept until the next request or an idle cycle
    task automatic send_vertex(input logic [31:0] px, py, pz, tu, tv,
                               input logic [15:0] nx, ny, nz);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= px; pos_y <= py; pos_z <= pz;
        tex_u <= tu; tex_v <= tv;
        norm_x <= nx; norm_y <= ny; norm_z <= nz;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_random_vertex();
        send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // idle and drained before touching the register
    task automatic write_mode(input logic v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (frames_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        renormalize_we <= 1'b1;
        renormalize_wd <= v;
        @(posedge clk);
        renormalize_we <= 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(1'b0);
        // extremes: most negative, most positive, zero and all-ones values
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 16'h8000, 16'h8000, 16'h8000);
        send_vertex(32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0,
                    16'h7fff, 16'h0, 16'hffff);
        send_vertex(32'h0, 32'h7fff_ffff, 32'hffff_ffff, 32'h0, 32'h7fff_ffff,
                    16'h4000, 16'hc000, 16'h0);
        // zero determinant: all texcoords equal
        send_vertex(0, 0, 0, 32'h1_0000, 32'h1_0000, 16'h4000, 0, 0);
        send_vertex(32'h1_0000, 0, 0, 32'h1_0000, 32'h1_0000, 0, 16'h4000, 0);
        send_vertex(0, 32'h1_0000, 0, 32'h1_0000, 32'h1_0000, 0, 0, 16'h4000);
        write_mode(1'b1);
        // degenerate face: all positions equal, negative determinant
        send_vertex(5, 5, 5, 0, 0, 1, 2, 3);
        send_vertex(5, 5, 5, 0, 32'h1_0000, 4, 5, 6);
        send_vertex(5, 5, 5, 32'h1_0000, 0, 7, 8, 9);
        // simple unit triangle
        send_vertex(0, 0, 0, 0, 0, 0, 0, 0);
        send_vertex(32'h1_0000, 0, 0, 32'h1_0000, 0, 0, 0, 0);
        send_vertex(0, 32'h1_0000, 0, 0, 32'h1_0000, 0, 0, 0);
        for (int phase = 0; phase < 4; phase++)
        begin
            write_mode(phase[0]);
            no_idle <= (phase == 2);
            for (int tri_idx = 0; tri_idx < 40; tri_idx++)
                repeat (3) send_random_vertex();
        end
        in_valid <= 1'b0;
        no_idle <= 1'b0;
        @(posedge clk);
        while (frames_pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ttf_pkg.sv
rtl/core/ttf_datapath.sv
rtl/core/ttf_ctrl.sv
rtl/core/triangle_tangent_frame.sv
tb/triangle_tangent_frame_checker.sv
tb/triangle_tangent_frame_tb.sv
